>>> sv/battery_soc_adjust_top_assert.svh
// assertion macros for the battery level adjuster checker
`ifndef BATTERY_SOC_ADJUST_TOP_ASSERT_SVH
`define BATTERY_SOC_ADJUST_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BSA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsa check failed");

// next-cycle implication, quiet during reset
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsa check failed");

// next-cycle implication that also runs through reset
`define BSA_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bsa reset check failed");

`endif

>>> sv/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

    // field widths
    localparam int LVL_W      = 15;
    localparam int EMPTY_W    = 10;
    localparam int PCT_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int ZRUN_W     = 2;

    // raw level forming
    localparam logic [LVL_W-1:0] PCT_SCALE = 15'd100;
    localparam int               LSB_SHIFT = 8;

    // scaled level: num * 10000 fits in 28 bits
    localparam int                DIVD_W    = 28;
    localparam int                DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);
    localparam int                T_W       = 14;
    localparam logic [T_W-1:0]    SCALE_FULL = 14'd10000;

    // offset curve
    localparam logic [T_W-1:0] OFS_LO   = 14'd2100;
    localparam logic [T_W-1:0] OFS_A    = 14'd3100;
    localparam logic [T_W-1:0] OFS_B    = 14'd7100;
    localparam logic [T_W-1:0] OFS_HI   = 14'd8100;
    localparam logic [T_W-1:0] OFS_BASE = 14'd300;
    localparam logic [T_W-1:0] OFS_STEP = 14'd150;
    localparam logic [T_W-1:0] OFS_TOP  = 14'd1200;

    // t*15/100 == (3t)/20, reciprocal of 20 scaled by 2^19 (exact for t < 8100)
    localparam int                 F_W        = 12;
    localparam int                 X3_W       = 16;
    localparam int                 FPROD_W    = 31;
    localparam logic [FPROD_W-1:0] RECIP20    = 31'd26215;
    localparam int                 RECIP20_SH = 19;

    // t/100, reciprocal of 100 scaled by 2^19 (exact for t <= 10000)
    localparam int                 PPROD_W     = 27;
    localparam logic [PPROD_W-1:0] RECIP100    = 27'd5243;
    localparam int                 RECIP100_SH = 19;
    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;

    localparam logic [ZRUN_W-1:0]  ZERO_LIMIT = 2'd3;

    // register reset values
    localparam logic [LVL_W-1:0]   RST_EMPTY_COND = 15'd100;
    localparam logic [EMPTY_W-1:0] RST_EMPTY      = 10'd20;
    localparam logic [LVL_W-1:0]   RST_FULL_LOW   = 15'd9250;
    localparam logic [LVL_W-1:0]   RST_FULL_HIGH  = 15'd9680;
    localparam logic [EMPTY_W-1:0] RST_FULL_KEEP  = 10'd30;
    localparam logic [LVL_W-1:0]   RST_FULL_DEF   = 15'd9350;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FULL   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_COND = 3'd0,
        CFG_EMPTY      = 3'd1,
        CFG_FULL_LOW   = 3'd2,
        CFG_FULL_HIGH  = 3'd3,
        CFG_FULL_KEEP  = 3'd4,
        CFG_FULL_DEF   = 3'd5,
        CFG_OFS_EN     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_OFS,
        ST_ADJ,
        ST_PCT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic ofs;
        logic adj;
        logic pct;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_full;
        logic bypass;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> sv/bsa_ctrl.sv
`default_nettype none

module bsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_stall,
    input  wire bsa_pkg::t_dp_sts i_sts,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output bsa_pkg::t_dp_cmd      o_cmd
);

    bsa_pkg::t_state                  r_state, n_state;
    logic [bsa_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic                             r_out_valid, n_out_valid;
    logic                             w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsa_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        w_out_free  = !r_out_valid || !i_out_stall;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            bsa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bsa_pkg::ST_PREP;
                end
            end
            bsa_pkg::ST_PREP: begin
                if (i_sts.is_full) begin
                    n_state = bsa_pkg::ST_DONE;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.bypass ? bsa_pkg::ST_OFS : bsa_pkg::ST_DIV;
                end
            end
            bsa_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == bsa_pkg::DIV_LAST) begin
                    n_state = bsa_pkg::ST_OFS;
                end
            end
            bsa_pkg::ST_OFS: begin
                o_cmd.ofs = 1'b1;
                n_state   = bsa_pkg::ST_ADJ;
            end
            bsa_pkg::ST_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = bsa_pkg::ST_PCT;
            end
            bsa_pkg::ST_PCT: begin
                o_cmd.pct = 1'b1;
                n_state   = bsa_pkg::ST_DONE;
            end
            bsa_pkg::ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = bsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != bsa_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> sv/bsa_datapath.sv
`default_nettype none

module bsa_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bsa_pkg::t_dp_cmd                 i_cmd_ctl,
    output bsa_pkg::t_dp_sts                      o_sts,
    input  wire logic                             i_cfg_we,
    input  wire logic [bsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_cmd,
    input  wire logic [bsa_pkg::BYTE_W-1:0]       i_level_msb,
    input  wire logic [bsa_pkg::BYTE_W-1:0]       i_level_lsb,
    output logic [bsa_pkg::PCT_W-1:0]             o_percent,
    output logic [bsa_pkg::LVL_W-1:0]             o_raw_level,
    output logic [bsa_pkg::LVL_W-1:0]             o_full_level_now
);

    // configuration
    logic [bsa_pkg::LVL_W-1:0]   r_empty_cond, r_full_low, r_full_high;
    logic [bsa_pkg::EMPTY_W-1:0] r_empty, r_keep;
    logic                        r_ofs_en;

    // kept state
    logic [bsa_pkg::LVL_W-1:0]   r_full_level, r_last_raw;
    logic [bsa_pkg::PCT_W-1:0]   r_last_pct;
    logic [bsa_pkg::ZRUN_W-1:0]  r_zero_run;

    // per-item working registers
    logic                        r_cmd;
    logic [bsa_pkg::LVL_W-1:0]   r_den;
    logic [bsa_pkg::LVL_W-1:0]   r_rem;
    logic [bsa_pkg::DIVD_W-1:0]  r_quo;
    logic [bsa_pkg::T_W-1:0]     r_t;
    logic [bsa_pkg::F_W-1:0]     r_f;
    logic [bsa_pkg::PCT_W-1:0]   r_pct_raw;

    // result registers
    logic [bsa_pkg::PCT_W-1:0]   r_out_percent;
    logic [bsa_pkg::LVL_W-1:0]   r_out_raw, r_out_full;

    logic [bsa_pkg::LVL_W-1:0]   w_raw, w_empty15, w_keep15, w_num, w_adj_full;
    logic [bsa_pkg::LVL_W:0]     w_trial, w_low_keep;
    logic                        w_qbit;
    logic [bsa_pkg::T_W-1:0]     w_t, w_t_adj;
    logic [bsa_pkg::X3_W-1:0]    w_x3;
    logic [bsa_pkg::FPROD_W-1:0] w_fprod;
    logic [bsa_pkg::PPROD_W-1:0] w_pprod;
    logic [bsa_pkg::ZRUN_W-1:0]  w_zrun_inc, w_zrun_next;
    logic [bsa_pkg::PCT_W-1:0]   w_pct_final;
    logic                        w_at_empty, w_full_low_den;

    // raw = msb*100 + lsb*100/256
    assign w_raw = bsa_pkg::LVL_W'(i_level_msb) * bsa_pkg::PCT_SCALE
                 + ((bsa_pkg::LVL_W'(i_level_lsb) * bsa_pkg::PCT_SCALE) >> bsa_pkg::LSB_SHIFT);

    assign w_empty15      = bsa_pkg::LVL_W'(r_empty);
    assign w_keep15       = bsa_pkg::LVL_W'(r_keep);
    assign w_at_empty     = (r_last_raw <= r_empty_cond);
    assign w_full_low_den = (r_full_level <= w_empty15);
    assign w_num          = (r_last_raw > w_empty15) ? (r_last_raw - w_empty15) : '0;

    assign o_sts.is_full = (r_cmd == bsa_pkg::CMD_FULL);
    assign o_sts.bypass  = w_at_empty || w_full_low_den;

    // restoring divider step
    assign w_trial = {r_rem, r_quo[bsa_pkg::DIVD_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    // cap at full scale, then 3t for the offset curve
    assign w_t     = (r_quo > bsa_pkg::DIVD_W'(bsa_pkg::SCALE_FULL)) ?
                     bsa_pkg::SCALE_FULL : r_quo[bsa_pkg::T_W-1:0];
    assign w_x3    = bsa_pkg::X3_W'(w_t) + bsa_pkg::X3_W'({w_t, 1'b0});
    assign w_fprod = bsa_pkg::FPROD_W'(w_x3) * bsa_pkg::RECIP20;

    always_comb begin
        w_t_adj = r_t;
        if (r_ofs_en && (r_t >= bsa_pkg::OFS_LO) && (r_t < bsa_pkg::OFS_HI)) begin
            if (r_t < bsa_pkg::OFS_A) begin
                w_t_adj = r_t + bsa_pkg::OFS_BASE - bsa_pkg::T_W'(r_f);
            end else if (r_t < bsa_pkg::OFS_B) begin
                w_t_adj = r_t - bsa_pkg::OFS_STEP;
            end else begin
                w_t_adj = r_t + bsa_pkg::T_W'(r_f) - bsa_pkg::OFS_TOP;
            end
        end
    end

    assign w_pprod = bsa_pkg::PPROD_W'(r_t) * bsa_pkg::RECIP100;

    // zero hold: a zero only shows on the third in a row
    always_comb begin
        w_zrun_inc  = r_zero_run + 1'b1;
        w_zrun_next = '0;
        w_pct_final = r_pct_raw;
        if (r_pct_raw == '0) begin
            if (w_zrun_inc >= bsa_pkg::ZERO_LIMIT) begin
                w_zrun_next = '0;
            end else begin
                w_zrun_next = w_zrun_inc;
                w_pct_final = r_last_pct;
            end
        end
    end

    // adaptive full level on charger full
    assign w_low_keep = {1'b0, r_full_low} + {1'b0, w_keep15};
    always_comb begin
        if (r_last_raw < r_full_low) begin
            w_adj_full = r_full_low;
        end else if (r_last_raw > r_full_high) begin
            w_adj_full = (r_full_high > w_keep15) ? (r_full_high - w_keep15) : '0;
        end else if ({1'b0, r_last_raw} > w_low_keep) begin
            w_adj_full = r_last_raw - w_keep15;
        end else begin
            w_adj_full = r_full_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_cond <= bsa_pkg::RST_EMPTY_COND;
            r_empty      <= bsa_pkg::RST_EMPTY;
            r_full_low   <= bsa_pkg::RST_FULL_LOW;
            r_full_high  <= bsa_pkg::RST_FULL_HIGH;
            r_keep       <= bsa_pkg::RST_FULL_KEEP;
            r_ofs_en     <= 1'b0;
            r_full_level <= bsa_pkg::RST_FULL_DEF;
            r_last_raw   <= '0;
            r_last_pct   <= '0;
            r_zero_run   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (bsa_pkg::t_cfg_idx'(i_cfg_index))
                    bsa_pkg::CFG_EMPTY_COND: r_empty_cond <= i_cfg_data;
                    bsa_pkg::CFG_EMPTY:      r_empty      <= i_cfg_data[bsa_pkg::EMPTY_W-1:0];
                    bsa_pkg::CFG_FULL_LOW:   r_full_low   <= i_cfg_data;
                    bsa_pkg::CFG_FULL_HIGH:  r_full_high  <= i_cfg_data;
                    bsa_pkg::CFG_FULL_KEEP:  r_keep       <= i_cfg_data[bsa_pkg::EMPTY_W-1:0];
                    // writing the default full level overwrites the tracked full level
                    bsa_pkg::CFG_FULL_DEF:   r_full_level <= i_cfg_data;
                    bsa_pkg::CFG_OFS_EN:     r_ofs_en     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd_ctl.load && (i_cmd == bsa_pkg::CMD_SAMPLE)) begin
                r_last_raw <= w_raw;
            end
            if (i_cmd_ctl.commit) begin
                if (r_cmd == bsa_pkg::CMD_FULL) begin
                    r_full_level <= w_adj_full;
                end else begin
                    r_last_pct <= w_pct_final;
                    r_zero_run <= w_zrun_next;
                end
            end
        end
    end

    // working and result registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_cmd <= i_cmd;
        end
        if (i_cmd_ctl.prep) begin
            r_rem <= '0;
            r_den <= r_full_level - w_empty15;
            if (w_at_empty) begin
                r_quo <= '0;
            end else if (w_full_low_den) begin
                r_quo <= bsa_pkg::DIVD_W'(bsa_pkg::SCALE_FULL);
            end else begin
                r_quo <= bsa_pkg::DIVD_W'(w_num) * bsa_pkg::DIVD_W'(bsa_pkg::SCALE_FULL);
            end
        end
        if (i_cmd_ctl.div_step) begin
            r_rem <= w_qbit ? bsa_pkg::LVL_W'(w_trial - {1'b0, r_den})
                            : w_trial[bsa_pkg::LVL_W-1:0];
            r_quo <= {r_quo[bsa_pkg::DIVD_W-2:0], w_qbit};
        end
        if (i_cmd_ctl.ofs) begin
            r_t <= w_t;
            r_f <= bsa_pkg::F_W'(w_fprod >> bsa_pkg::RECIP20_SH);
        end
        if (i_cmd_ctl.adj) begin
            r_t <= w_t_adj;
        end
        if (i_cmd_ctl.pct) begin
            r_pct_raw <= bsa_pkg::PCT_W'(w_pprod >> bsa_pkg::RECIP100_SH);
        end
        if (i_cmd_ctl.commit) begin
            r_out_raw <= r_last_raw;
            if (r_cmd == bsa_pkg::CMD_FULL) begin
                r_out_percent <= r_last_pct;
                r_out_full    <= w_adj_full;
            end else begin
                r_out_percent <= w_pct_final;
                r_out_full    <= r_full_level;
            end
        end
    end

    assign o_percent        = r_out_percent;
    assign o_raw_level      = r_out_raw;
    assign o_full_level_now = r_out_full;

endmodule

`default_nettype wire

>>> sv/battery_soc_adjust_top.sv
// channel   direction  handshake                  payload
// in        to block   i_in_valid / o_in_stall    i_cmd, i_level_msb, i_level_lsb
// out       from block o_out_valid / i_out_stall  o_percent, o_raw_level, o_full_level_now
// cfg       to block   i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// one request at a time: a gauge sample that needs scaling runs through the 28-step
// restoring divider before the next request is accepted
// a sample at or below the empty condition, or with full not above empty, skips the
// divider; a charger-full request skips the divider, the offset curve and the percent step
// reset is synchronous and active low; configuration and adaptive state return to defaults
// a stalled result waits in the output register; the controller holds its last step
// until the register frees, and the block stays stalled on its input meanwhile
`default_nettype none

module battery_soc_adjust_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_cmd,
    input  wire logic [bsa_pkg::BYTE_W-1:0]     i_level_msb,
    input  wire logic [bsa_pkg::BYTE_W-1:0]     i_level_lsb,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bsa_pkg::PCT_W-1:0]           o_percent,
    output logic [bsa_pkg::LVL_W-1:0]           o_raw_level,
    output logic [bsa_pkg::LVL_W-1:0]           o_full_level_now,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [bsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // step commands down, per-request status back up
    bsa_pkg::t_dp_cmd w_cmd_ctl;
    bsa_pkg::t_dp_sts w_sts;

    // sequencer: accept, prepare, divide, bend, to percent, hand over
    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd_ctl)
    );

    // registers, divider, offset curve, zero hold and full level tracking
    bsa_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_ctl        (w_cmd_ctl),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_level_msb      (i_level_msb),
        .i_level_lsb      (i_level_lsb),
        .o_percent        (o_percent),
        .o_raw_level      (o_raw_level),
        .o_full_level_now (o_full_level_now)
    );

endmodule

`default_nettype wire

>>> sv/bsa_checker.sv
`default_nettype none

`include "battery_soc_adjust_top_assert.svh"

module bsa_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [bsa_pkg::PCT_W-1:0]      o_percent,
    input wire logic [bsa_pkg::LVL_W-1:0]      o_raw_level,
    input wire logic [bsa_pkg::LVL_W-1:0]      o_full_level_now
);

    // one request in flight: busy right after an acceptance
    `BSA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // reported percent never above full
    `BSA_ASSERT_NOW(a_pct_range, o_out_valid, o_percent <= bsa_pkg::PCT_MAX)

    // a stalled result stays put
    `BSA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_percent) && $stable(o_raw_level) && $stable(o_full_level_now))

    // reset leaves the block empty and ready
    `BSA_ASSERT_RESET(a_reset_clear, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind battery_soc_adjust_top bsa_checker u_bsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_percent        (o_percent),
    .o_raw_level      (o_raw_level),
    .o_full_level_now (o_full_level_now)
);

`default_nettype wire
